// ===== src/tcs_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the console.
package tcs_pkg;

    // Screen and scrollback geometry
    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int HISTORY_ROWS = 200;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int SROW_W = 5;
    localparam int COL_W  = 7;
    localparam int LINE_W = 8;
    localparam int ADDR_W = $clog2(HISTORY_ROWS * COLS);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PAGE_UP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAGE_DOWN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Configuration reset value
    localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd15;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;       // capture the incoming request
        logic blank_step;  // write one space of the row sweep
        logic exec;        // perform the request's update
        logic load_out;    // load the result register
    } tcs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_blank;  // printable char targets a row not yet blanked
        logic blank_last;  // sweep is at the last column
    } tcs_status_t;

endpackage

// ===== src/tcs_ctrl.sv =====
// Controller state machine: request intake, row blanking sweep, execution, result handoff.
module tcs_ctrl
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  tcs_status_t status,
    output tcs_cmd_t    ctl
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_BLANK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.need_blank)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_BLANK:
            begin
                ctl.blank_step = 1'b1;
                if (status.blank_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/tcs_datapath.sv =====
// Datapath: cell store, row valid flags, cursor/window/ring registers and result registers.
module tcs_datapath
    import tcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcs_cmd_t          ctl,
    output tcs_status_t       status,
    input  logic [CMD_W-1:0]  command,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [SROW_W-1:0] screen_row,
    input  logic [COL_W-1:0]  screen_col,
    input  logic              cfg_we,
    input  logic [CHAR_W-1:0] cfg_data,
    output logic [CHAR_W-1:0] cell_char,
    output logic [CHAR_W-1:0] cell_attribute,
    output logic [LINE_W-1:0] cursor_line,
    output logic [COL_W-1:0]  cursor_column,
    output logic [LINE_W-1:0] window_top
);

    // Lowest window position that still shows the given cursor line
    function automatic logic [LINE_W-1:0] bottom_of(input logic [LINE_W-1:0] line);
        logic [LINE_W:0] l1;
        l1 = {1'b0, line} + (LINE_W+1)'(1);
        bottom_of = (l1 >= (LINE_W+1)'(ROWS)) ? LINE_W'(l1 - (LINE_W+1)'(ROWS)) : '0;
    endfunction

    // Request registers
    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [SROW_W-1:0] srow_reg;
    logic [COL_W-1:0]  scol_reg;

    // Console state
    logic [LINE_W-1:0] ring_reg;
    logic [LINE_W-1:0] line_reg;
    logic [COL_W-1:0]  col_reg;
    logic [LINE_W-1:0] win_reg;
    logic [CHAR_W-1:0] attr_reg;
    logic              row_valid_reg [HISTORY_ROWS];
    logic [COL_W-1:0]  blank_cnt_reg;

    // Cell store and read data
    logic [CHAR_W-1:0] mem [HISTORY_ROWS*COLS];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_hit_reg;

    // Result registers
    logic [CHAR_W-1:0] cell_char_reg;
    logic [CHAR_W-1:0] cell_attr_reg;
    logic [LINE_W-1:0] cur_line_out_reg;
    logic [COL_W-1:0]  cur_col_out_reg;
    logic [LINE_W-1:0] win_out_reg;

    // Decode and combinational values
    logic              is_put;
    logic              is_bs;
    logic              is_nl;
    logic              is_char;
    logic              is_read;
    logic              bs_en;
    logic [LINE_W-1:0] bs_line;
    logic [COL_W-1:0]  bs_col;
    logic [LINE_W:0]   rd_line;
    logic              rd_in_range;
    logic [LINE_W-1:0] acc_line;
    logic [COL_W-1:0]  acc_col;
    logic [LINE_W:0]   phys_sum;
    logic [LINE_W-1:0] acc_phys;
    logic              acc_row_valid;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;
    logic              nl_wrap;
    logic [LINE_W-1:0] nl_phys;
    logic [LINE_W-1:0] ring_inc;
    logic [COL_W:0]    col_inc;
    logic              do_newline;
    logic [LINE_W-1:0] line_n;
    logic [COL_W-1:0]  col_n;
    logic [LINE_W-1:0] ring_n;
    logic [LINE_W-1:0] win_n;
    logic [LINE_W:0]   win_down;
    logic [LINE_W-1:0] cur_bottom;

    assign is_put  = (cmd_reg == CMD_PUT);
    assign is_bs   = is_put && (ch_reg == CH_BACKSPACE);
    assign is_nl   = is_put && (ch_reg == CH_NEWLINE);
    assign is_char = is_put && !is_bs && !is_nl;
    assign is_read = (cmd_reg == CMD_READ);

    // Backspace target cell
    assign bs_en   = (col_reg != '0) || (line_reg != '0);
    assign bs_line = (col_reg != '0) ? line_reg : line_reg - LINE_W'(1);
    assign bs_col  = (col_reg != '0) ? col_reg - COL_W'(1) : COL_W'(COLS - 1);

    // Read target and range check
    assign rd_line     = {1'b0, win_reg} + (LINE_W+1)'(srow_reg);
    assign rd_in_range = (srow_reg < SROW_W'(ROWS)) && (scol_reg < COL_W'(COLS))
                         && (rd_line < (LINE_W+1)'(HISTORY_ROWS));

    // Access line/column select, then logical to physical row
    assign acc_line = is_read ? rd_line[LINE_W-1:0] : (is_bs ? bs_line : line_reg);
    always_comb
    begin
        if (ctl.blank_step)
        begin
            acc_col = blank_cnt_reg;
        end
        else if (is_read)
        begin
            acc_col = scol_reg;
        end
        else if (is_bs)
        begin
            acc_col = bs_col;
        end
        else
        begin
            acc_col = col_reg;
        end
    end

    assign phys_sum = {1'b0, ring_reg} + {1'b0, acc_line};
    assign acc_phys = (phys_sum >= (LINE_W+1)'(HISTORY_ROWS))
                      ? LINE_W'(phys_sum - (LINE_W+1)'(HISTORY_ROWS))
                      : phys_sum[LINE_W-1:0];
    assign acc_row_valid = row_valid_reg[acc_phys];
    assign mem_addr = ADDR_W'(acc_phys) * ADDR_W'(COLS) + ADDR_W'(acc_col);

    // Next line handling; the cursor row is acc_phys for put requests other than backspace
    assign nl_wrap  = (line_reg == LINE_W'(HISTORY_ROWS - 1));
    assign ring_inc = (ring_reg == LINE_W'(HISTORY_ROWS - 1)) ? '0 : ring_reg + LINE_W'(1);
    assign nl_phys  = nl_wrap ? ring_reg
                      : ((acc_phys == LINE_W'(HISTORY_ROWS - 1)) ? '0 : acc_phys + LINE_W'(1));
    assign col_inc  = {1'b0, col_reg} + (COL_W+1)'(1);

    // Cursor update for a put
    always_comb
    begin
        line_n     = line_reg;
        col_n      = col_reg;
        ring_n     = ring_reg;
        do_newline = 1'b0;
        if (is_bs)
        begin
            if (bs_en)
            begin
                line_n = bs_line;
                col_n  = bs_col;
            end
        end
        else if (is_nl)
        begin
            do_newline = 1'b1;
        end
        else
        begin
            col_n = col_inc[COL_W-1:0];
            if (col_inc >= (COL_W+1)'(COLS))
            begin
                do_newline = 1'b1;
            end
        end
        if (do_newline)
        begin
            col_n = '0;
            if (nl_wrap)
            begin
                ring_n = ring_inc;
            end
            else
            begin
                line_n = line_reg + LINE_W'(1);
            end
        end
    end

    // Window movement
    assign cur_bottom = bottom_of(line_reg);
    assign win_down   = {1'b0, win_reg} + (LINE_W+1)'(ROWS - 1);
    always_comb
    begin
        case (cmd_reg)
            CMD_PAGE_UP:
            begin
                win_n = (win_reg >= LINE_W'(ROWS - 1)) ? win_reg - LINE_W'(ROWS - 1) : '0;
            end
            CMD_PAGE_DOWN:
            begin
                win_n = (win_down > {1'b0, cur_bottom}) ? cur_bottom : win_down[LINE_W-1:0];
            end
            default:
            begin
                win_n = win_reg;
            end
        endcase
    end

    // Status to controller
    assign status.need_blank = is_char && !acc_row_valid;
    assign status.blank_last = (blank_cnt_reg == COL_W'(COLS - 1));

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= command;
            ch_reg   <= char_code;
            srow_reg <= screen_row;
            scol_reg <= screen_col;
        end
    end

    // Console state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            line_reg <= '0;
            col_reg  <= '0;
            win_reg  <= '0;
        end
        else if (ctl.exec)
        begin
            case (cmd_reg)
                CMD_PUT:
                begin
                    ring_reg <= ring_n;
                    line_reg <= line_n;
                    col_reg  <= col_n;
                    win_reg  <= bottom_of(line_n);
                end
                CMD_CLEAR:
                begin
                    ring_reg <= '0;
                    line_reg <= '0;
                    col_reg  <= '0;
                    win_reg  <= '0;
                end
                default:
                begin
                    win_reg <= win_n;
                end
            endcase
        end
    end

    // Attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_data;
        end
    end

    // Blank sweep column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_cnt_reg <= '0;
        end
        else if (ctl.latch)
        begin
            blank_cnt_reg <= '0;
        end
        else if (ctl.blank_step)
        begin
            blank_cnt_reg <= status.blank_last ? '0 : blank_cnt_reg + COL_W'(1);
        end
    end

    // Row valid flags: an invalid row reads as all spaces
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_ROWS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else if (ctl.exec && (cmd_reg == CMD_CLEAR))
        begin
            for (int i = 0; i < HISTORY_ROWS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else if (ctl.exec && is_put && do_newline)
        begin
            row_valid_reg[nl_phys] <= 1'b0;
        end
        else if (ctl.blank_step && status.blank_last)
        begin
            row_valid_reg[acc_phys] <= 1'b1;
        end
    end

    // Cell store write and registered read
    assign mem_we    = ctl.blank_step
                       || (ctl.exec && (is_char || (is_bs && bs_en && acc_row_valid)));
    assign mem_wdata = (ctl.exec && is_char) ? ch_reg : CH_SPACE;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (ctl.exec && is_read)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && is_read)
        begin
            rd_hit_reg <= rd_in_range && acc_row_valid;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            if (is_read)
            begin
                cell_char_reg <= rd_hit_reg ? rd_data_reg : CH_SPACE;
                cell_attr_reg <= attr_reg;
            end
            else
            begin
                cell_char_reg <= '0;
                cell_attr_reg <= '0;
            end
            cur_line_out_reg <= line_reg;
            cur_col_out_reg  <= col_reg;
            win_out_reg      <= win_reg;
        end
    end

    assign cell_char      = cell_char_reg;
    assign cell_attribute = cell_attr_reg;
    assign cursor_line    = cur_line_out_reg;
    assign cursor_column  = cur_col_out_reg;
    assign window_top     = win_out_reg;

endmodule

// ===== src/text_console_scrollback.sv =====
// Flow: a request is taken in S_IDLE and performed in S_EXEC; its result is loaded into
// the output register in S_DONE once that register is free, then S_IDLE takes the next one.
// A printable character landing in a row not yet blanked first runs S_BLANK, a sweep over
// all 80 columns (one write per cycle on the cell store's single write port), before S_EXEC.
// A new request is taken while the previous result still waits in the output register.
// Reset: cursor, window, ring start zero, attribute 15, all rows flagged blank, no clear pass.
module text_console_scrollback
    import tcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [SROW_W-1:0] screen_row,
    input  logic [COL_W-1:0]  screen_col,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] cell_char,
    output logic [CHAR_W-1:0] cell_attribute,
    output logic [LINE_W-1:0] cursor_line,
    output logic [COL_W-1:0]  cursor_column,
    output logic [LINE_W-1:0] window_top,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CHAR_W-1:0] cfg_data
);

    tcs_cmd_t    ctl;
    tcs_status_t status;

    // Attribute register is always writable
    assign cfg_ready = 1'b1;

    tcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctl       (ctl)
    );

    tcs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .command        (command),
        .char_code      (char_code),
        .screen_row     (screen_row),
        .screen_col     (screen_col),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .cursor_line    (cursor_line),
        .cursor_column  (cursor_column),
        .window_top     (window_top)
    );

endmodule

// ===== verif/text_console_scrollback_test.sv =====
// Self-checking testbench for the text console scrollback engine.
module text_console_scrollback_test;
    import tcs_pkg::*;

    // Unused command codes, which only report the state
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int IDLE_PCT    = 28;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 120;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attribute;
        logic [LINE_W-1:0] cursor_line;
        logic [COL_W-1:0]  cursor_column;
        logic [LINE_W-1:0] window_top;
    } console_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [CMD_W-1:0]  command = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [SROW_W-1:0] screen_row = '0;
    logic [COL_W-1:0]  screen_col = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attribute;
    logic [LINE_W-1:0] cursor_line;
    logic [COL_W-1:0]  cursor_column;
    logic [LINE_W-1:0] window_top;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAR_W-1:0] cfg_data = '0;

    // Shadow copy of the console state
    logic [CHAR_W-1:0] shadow_cells [HISTORY_ROWS*COLS];
    int unsigned       shadow_ring;
    int unsigned       shadow_line;
    int unsigned       shadow_col;
    int unsigned       shadow_top;
    logic [CHAR_W-1:0] shadow_attr = ATTR_RESET;

    console_result_t   pending_results [$];
    int unsigned       errors = 0;
    bit                steady = 1'b0;

    text_console_scrollback i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .char_code      (char_code),
        .screen_row     (screen_row),
        .screen_col     (screen_col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .cursor_line    (cursor_line),
        .cursor_column  (cursor_column),
        .window_top     (window_top),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Console predictor
    // ---------------------------------------------------------------
    function automatic int unsigned cell_addr(int unsigned line, int unsigned col);
        int unsigned phys;
        phys = (shadow_ring + (line % HISTORY_ROWS)) % HISTORY_ROWS;
        return phys * COLS + (col % COLS);
    endfunction

    function automatic int unsigned bottom_row();
        return (shadow_line + 1 >= ROWS) ? shadow_line + 1 - ROWS : 0;
    endfunction

    function automatic void clear_console();
        for (int i = 0; i < HISTORY_ROWS * COLS; i++)
            shadow_cells[i] = CH_SPACE;
        shadow_ring = 0;
        shadow_line = 0;
        shadow_col  = 0;
        shadow_top  = 0;
    endfunction

    // Cursor to column 0 of a fresh row; oldest row drops out when full
    function automatic void open_fresh_row();
        shadow_col = 0;
        if (shadow_line + 1 >= HISTORY_ROWS)
        begin
            shadow_ring = (shadow_ring + 1) % HISTORY_ROWS;
            shadow_line = HISTORY_ROWS - 1;
        end
        else
        begin
            shadow_line++;
        end
        for (int c = 0; c < COLS; c++)
            shadow_cells[cell_addr(shadow_line, c)] = CH_SPACE;
    endfunction

    function automatic void put_char(logic [CHAR_W-1:0] ch);
        if (ch == CH_BACKSPACE)
        begin
            if (shadow_col > 0)
            begin
                shadow_col--;
                shadow_cells[cell_addr(shadow_line, shadow_col)] = CH_SPACE;
            end
            else if (shadow_line > 0)
            begin
                shadow_line--;
                shadow_col = COLS - 1;
                shadow_cells[cell_addr(shadow_line, shadow_col)] = CH_SPACE;
            end
        end
        else if (ch == CH_NEWLINE)
        begin
            open_fresh_row();
        end
        else
        begin
            shadow_cells[cell_addr(shadow_line, shadow_col)] = ch;
            shadow_col++;
            if (shadow_col >= COLS)
                open_fresh_row();
        end
        shadow_top = bottom_row();
    endfunction

    function automatic console_result_t predict_response(logic [CMD_W-1:0] cmd,
            logic [CHAR_W-1:0] ch, logic [SROW_W-1:0] srow, logic [COL_W-1:0] scol);
        console_result_t res;
        int unsigned     line;
        res  = '0;
        line = shadow_top + srow;
        case (cmd)
            CMD_PUT:   put_char(ch);
            CMD_CLEAR: clear_console();
            CMD_PAGE_UP:
                shadow_top = (shadow_top >= ROWS - 1) ? shadow_top - (ROWS - 1) : 0;
            CMD_PAGE_DOWN:
            begin
                shadow_top += ROWS - 1;
                if (shadow_top > bottom_row())
                    shadow_top = bottom_row();
            end
            CMD_READ:
            begin
                res.cell_attribute = shadow_attr;
                if (srow < ROWS && scol < COLS && line < HISTORY_ROWS)
                    res.cell_char = shadow_cells[cell_addr(line, scol)];
                else
                    res.cell_char = CH_SPACE;
            end
            default: ;
        endcase
        res.cursor_line   = shadow_line[LINE_W-1:0];
        res.cursor_column = shadow_col[COL_W-1:0];
        res.window_top    = shadow_top[LINE_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request and configuration channels
    // ---------------------------------------------------------------
    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Send one request, holding it until taken, then record its expected result
    task automatic issue_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
            logic [SROW_W-1:0] srow, logic [COL_W-1:0] scol);
        @(negedge clk);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command    <= cmd;
        char_code  <= ch;
        screen_row <= srow;
        screen_col <= scol;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_results.push_back(predict_response(cmd, ch, srow, scol));
    endtask

    // Stop sending and wait until every expected result is back
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(logic [CHAR_W-1:0] value);
        quiesce();
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow_attr = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side stalls at random
    always @(negedge clk)
        out_stall <= take_gap();

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] exp, logic [7:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        console_result_t exp;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got char %0d line %0d",
                         $time, cell_char, cursor_line);
                errors++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("cell_char", exp.cell_char, cell_char);
                check_field("cell_attribute", exp.cell_attribute, cell_attribute);
                check_field("cursor_line", exp.cursor_line, cursor_line);
                check_field("cursor_column", {1'b0, exp.cursor_column}, {1'b0, cursor_column});
                check_field("window_top", exp.window_top, window_top);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("text_console_scrollback_test: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset state, backspace at the home position and spare commands
    task automatic reset_state_test();
        issue_request(CMD_PUT, CH_BACKSPACE, '0, '0);
        issue_request(CMD_READ, 8'hFF, 5'd0, 7'd0);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            issue_request(c[CMD_W-1:0], 8'hFF, 5'h1F, 7'h7F);
    endtask

    // Character extremes, newline, backspace over a row boundary, reads, paging, clear
    task automatic directed_edit_test();
        issue_request(CMD_PUT, 8'h00, '1, '1);
        issue_request(CMD_PUT, 8'hFF, '0, '0);
        issue_request(CMD_PUT, 8'h41, '0, '0);
        issue_request(CMD_PUT, CH_NEWLINE, '0, '0);
        issue_request(CMD_PUT, CH_BACKSPACE, '0, '0);
        issue_request(CMD_READ, '0, 5'd0, 7'd0);
        issue_request(CMD_READ, '0, 5'd0, 7'd1);
        issue_request(CMD_READ, '0, 5'd0, 7'd2);
        issue_request(CMD_READ, '0, SROW_W'(ROWS - 1), COL_W'(COLS - 1));
        issue_request(CMD_READ, '0, SROW_W'(ROWS), 7'd0);
        issue_request(CMD_READ, '0, 5'd0, COL_W'(COLS));
        issue_request(CMD_READ, '0, 5'h1F, 7'h7F);
        issue_request(CMD_PAGE_UP, '0, '0, '0);
        issue_request(CMD_PAGE_DOWN, '0, '0, '0);
        issue_request(CMD_CLEAR, 8'hFF, '1, '1);
        issue_request(CMD_READ, '0, 5'd0, 7'd0);
    endtask

    // Fill a row past the last column, then back up across the boundary
    task automatic line_wrap_test();
        for (int i = 0; i < COLS + 3; i++)
            issue_request(CMD_PUT, CHAR_W'($urandom_range(126, 33)), SROW_W'($urandom),
                          COL_W'($urandom));
        repeat (6) issue_request(CMD_PUT, CH_BACKSPACE, '0, '0);
        for (int c = 0; c < 6; c++)
            issue_request(CMD_READ, '0, SROW_W'($urandom_range(1, 0)),
                          COL_W'($urandom_range(COLS - 1)));
    endtask

    // Run the store full so the oldest rows drop out, then page through history
    task automatic scrollback_fill_test();
        int unsigned full_lines;
        full_lines = 0;
        while (full_lines < 20)
        begin
            if ($urandom_range(3) == 0)
                issue_request(CMD_PUT, CHAR_W'($urandom_range(255)), SROW_W'($urandom),
                              COL_W'($urandom));
            else
                issue_request(CMD_PUT, CH_NEWLINE, SROW_W'($urandom), COL_W'($urandom));
            if (shadow_line == HISTORY_ROWS - 1)
                full_lines++;
        end
        repeat (HISTORY_ROWS / (ROWS - 1) + 1)
        begin
            issue_request(CMD_PAGE_UP, CHAR_W'($urandom), SROW_W'($urandom),
                          COL_W'($urandom));
            issue_request(CMD_READ, '0, SROW_W'($urandom_range(ROWS - 1)),
                          COL_W'($urandom_range(COLS - 1)));
        end
        repeat (HISTORY_ROWS / (ROWS - 1) + 1)
        begin
            issue_request(CMD_PAGE_DOWN, CHAR_W'($urandom), SROW_W'($urandom),
                          COL_W'($urandom));
            issue_request(CMD_READ, '0, SROW_W'($urandom_range(ROWS - 1)),
                          COL_W'($urandom_range(COLS - 1)));
        end
    endtask

    // Random mix of commands; optionally the sender waits for all results midway
    task automatic random_session_test(int unsigned count, bit pause_midway);
        int unsigned roll;
        int unsigned pick;
        logic [CHAR_W-1:0] ch;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                quiesce();
            roll = $urandom_range(99);
            pick = $urandom_range(99);
            if (roll < 55)
            begin
                if (pick < 12)
                    ch = CH_NEWLINE;
                else if (pick < 19)
                    ch = CH_BACKSPACE;
                else
                    ch = CHAR_W'($urandom_range(255));
                issue_request(CMD_PUT, ch, SROW_W'($urandom), COL_W'($urandom));
            end
            else if (roll < 78)
            begin
                if (pick < 90)
                    issue_request(CMD_READ, CHAR_W'($urandom),
                                  SROW_W'($urandom_range(ROWS - 1)),
                                  COL_W'($urandom_range(COLS - 1)));
                else
                    issue_request(CMD_READ, CHAR_W'($urandom), SROW_W'($urandom),
                                  COL_W'($urandom));
            end
            else if (roll < 86)
                issue_request(CMD_PAGE_UP, CHAR_W'($urandom), SROW_W'($urandom),
                              COL_W'($urandom));
            else if (roll < 95)
                issue_request(CMD_PAGE_DOWN, CHAR_W'($urandom), SROW_W'($urandom),
                              COL_W'($urandom));
            else if (roll < 96)
                issue_request(CMD_CLEAR, CHAR_W'($urandom), SROW_W'($urandom),
                              COL_W'($urandom));
            else
                issue_request(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)),
                              CHAR_W'($urandom), SROW_W'($urandom), COL_W'($urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        clear_console();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        reset_state_test();
        directed_edit_test();

        write_attribute(8'hFF);
        line_wrap_test();
        scrollback_fill_test();

        write_attribute(8'h00);
        random_session_test(400, 1'b0);

        // no idling on either side for this phase
        write_attribute(CHAR_W'($urandom_range(254, 1)));
        steady = 1'b1;
        random_session_test(400, 1'b0);
        steady = 1'b0;

        write_attribute(CHAR_W'($urandom_range(255)));
        random_session_test(400, 1'b1);

        write_attribute(ATTR_RESET);
        random_session_test(400, 1'b0);

        quiesce();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("text_console_scrollback_test: PASS");
        else
            $display("text_console_scrollback_test: FAIL");
        $finish;
    end

endmodule
